// ===== hw/rtl/shtp_pkg.sv =====
package shtp_pkg;

  localparam int unsigned HEADER_BYTES_DEF = 4;

  localparam logic [2:0] CMD_INTN_FALL   = 3'd0;
  localparam logic [2:0] CMD_HEADER_DONE = 3'd1;
  localparam logic [2:0] CMD_BODY_DONE   = 3'd2;
  localparam logic [2:0] CMD_SPI_ERROR   = 3'd3;
  localparam logic [2:0] CMD_POLL        = 3'd4;
  localparam logic [2:0] CMD_WRITE_REQ   = 3'd5;
  localparam logic [2:0] CMD_WRITE_DONE  = 3'd6;
  localparam logic [2:0] CMD_UNUSED      = 3'd7;

  localparam logic [1:0] PHASE_IDLE   = 2'd0;
  localparam logic [1:0] PHASE_HEADER = 2'd1;
  localparam logic [1:0] PHASE_BODY   = 2'd2;
  localparam logic [1:0] PHASE_WRITE  = 2'd3;

  localparam logic [1:0] RD_NONE   = 2'd0;
  localparam logic [1:0] RD_HEADER = 2'd1;
  localparam logic [1:0] RD_BODY   = 2'd2;

  localparam logic [2:0] WS_NONE    = 3'd0;
  localparam logic [2:0] WS_GRANTED = 3'd1;
  localparam logic [2:0] WS_BUSY    = 3'd2;
  localparam logic [2:0] WS_BAD_LEN = 3'd3;
  localparam logic [2:0] WS_EMPTY   = 3'd4;

  localparam logic [1:0] CFG_RX_BUFFER_SIZE = 2'd0;
  localparam logic [1:0] CFG_TX_BUFFER_SIZE = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_MS     = 2'd2;

  localparam logic [14:0] RX_BUFFER_SIZE_RST = 15'd384;
  localparam logic [14:0] TX_BUFFER_SIZE_RST = 15'd256;
  localparam logic [15:0] TIMEOUT_MS_RST     = 16'd20;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  header_low;
    logic [7:0]  header_high;
    logic [15:0] write_length;
    logic        write_ok;
    logic [31:0] now_ms;
    logic [31:0] now_us;
  } item_t;

  typedef struct packed {
    logic [14:0] rx_buffer_size;
    logic [14:0] tx_buffer_size;
    logic [15:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic        intn_pending;
    logic        packet_ready;
    logic [14:0] pending_length;
    logic [31:0] pending_stamp;
    logic [31:0] phase_start_ms;
    logic [31:0] rx_count;
    logic [31:0] err_count;
  } state_t;

  typedef struct packed {
    state_t st;
    logic   go;
  } start_t;

  typedef struct packed {
    logic [1:0]  read_start;
    logic [14:0] read_length;
    logic        chip_select;
    logic [1:0]  phase_now;
    logic        packet_delivered;
    logic [14:0] packet_length;
    logic [31:0] packet_stamp;
    logic [2:0]  write_status;
    logic        watchdog_fired;
    logic [31:0] packets_received;
    logic [31:0] errors_seen;
  } result_t;

endpackage

// ===== hw/rtl/shtp_cfg.sv =====
module shtp_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  output shtp_pkg::cfg_t   cfg
);
  import shtp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rx_buffer_size <= RX_BUFFER_SIZE_RST;
      cfg.tx_buffer_size <= TX_BUFFER_SIZE_RST;
      cfg.timeout_ms     <= TIMEOUT_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RX_BUFFER_SIZE: cfg.rx_buffer_size <= cfg_data[14:0];
        CFG_TX_BUFFER_SIZE: cfg.tx_buffer_size <= cfg_data[14:0];
        CFG_TIMEOUT_MS:     cfg.timeout_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/shtp_step.sv =====
module shtp_step #(
  parameter int unsigned HEADER_BYTES = shtp_pkg::HEADER_BYTES_DEF
) (
  input  shtp_pkg::state_t  state,
  input  shtp_pkg::item_t   item,
  input  shtp_pkg::cfg_t    cfg,
  output shtp_pkg::state_t  state_next,
  output shtp_pkg::result_t result
);
  import shtp_pkg::*;

  localparam logic [14:0] HDR_LEN = 15'(HEADER_BYTES);

  state_t      s;
  start_t      ts;
  logic [14:0] raw_len;
  logic [14:0] len;
  logic [31:0] elapsed;
  logic [1:0]  rd_start;
  logic [14:0] rd_len;
  logic        delivered;
  logic [14:0] dlen;
  logic [31:0] dstamp;
  logic [2:0]  wstat;
  logic        wd;

  function automatic start_t try_start(state_t st, logic [31:0] ms, logic [31:0] us);
    start_t r;
    r.st = st;
    r.go = 1'b0;
    if (st.phase == PHASE_IDLE && st.intn_pending && !st.packet_ready) begin
      r.st.phase          = PHASE_HEADER;
      r.st.pending_stamp  = us;
      r.st.phase_start_ms = ms;
      r.st.intn_pending   = 1'b0;
      r.go                = 1'b1;
    end
    return r;
  endfunction

  // continuation bit dropped, then clamped to the buffer
  assign raw_len = {item.header_high[6:0], item.header_low};
  assign len     = (raw_len > cfg.rx_buffer_size) ? cfg.rx_buffer_size : raw_len;
  assign elapsed = item.now_ms - state.phase_start_ms;

  always_comb begin
    s         = state;
    ts        = '0;
    rd_start  = RD_NONE;
    rd_len    = '0;
    delivered = 1'b0;
    dlen      = '0;
    dstamp    = '0;
    wstat     = WS_NONE;
    wd        = 1'b0;
    case (item.cmd)
      CMD_INTN_FALL: begin
        s.intn_pending = 1'b1;
        ts = try_start(s, item.now_ms, item.now_us);
        s  = ts.st;
        if (ts.go) begin
          rd_start = RD_HEADER;
          rd_len   = HDR_LEN;
        end
      end
      CMD_HEADER_DONE: begin
        if (s.phase == PHASE_HEADER) begin
          if (len <= HDR_LEN) begin
            s.phase = PHASE_IDLE;
            ts = try_start(s, item.now_ms, item.now_us);
            s  = ts.st;
            if (ts.go) begin
              rd_start = RD_HEADER;
              rd_len   = HDR_LEN;
            end
          end else begin
            s.pending_length = len;
            s.phase          = PHASE_BODY;
            s.phase_start_ms = item.now_ms;
            rd_start         = RD_BODY;
            rd_len           = len - HDR_LEN;
          end
        end
      end
      CMD_BODY_DONE: begin
        if (s.phase == PHASE_BODY) begin
          s.phase        = PHASE_IDLE;
          s.rx_count     = s.rx_count + 32'd1;
          s.packet_ready = 1'b1;
        end
      end
      CMD_SPI_ERROR: begin
        s.err_count = s.err_count + 32'd1;
        s.phase     = PHASE_IDLE;
        ts = try_start(s, item.now_ms, item.now_us);
        s  = ts.st;
        if (ts.go) begin
          rd_start = RD_HEADER;
          rd_len   = HDR_LEN;
        end
      end
      CMD_POLL: begin
        if ((s.phase == PHASE_HEADER || s.phase == PHASE_BODY) &&
            elapsed > {16'd0, cfg.timeout_ms}) begin
          s.phase        = PHASE_IDLE;
          s.packet_ready = 1'b0;
          s.err_count    = s.err_count + 32'd1;
          wd             = 1'b1;
          ts = try_start(s, item.now_ms, item.now_us);
          s  = ts.st;
          if (ts.go) begin
            rd_start = RD_HEADER;
            rd_len   = HDR_LEN;
          end
        end
        if (s.packet_ready) begin
          delivered      = 1'b1;
          dlen           = s.pending_length;
          dstamp         = s.pending_stamp;
          s.packet_ready = 1'b0;
          ts = try_start(s, item.now_ms, item.now_us);
          s  = ts.st;
          if (ts.go) begin
            rd_start = RD_HEADER;
            rd_len   = HDR_LEN;
          end
        end
      end
      CMD_WRITE_REQ: begin
        if (item.write_length == 16'd0) begin
          wstat = WS_EMPTY;
        end else if (item.write_length > {1'b0, cfg.tx_buffer_size}) begin
          wstat = WS_BAD_LEN;
        end else if (s.phase != PHASE_IDLE) begin
          wstat = WS_BUSY;
        end else begin
          wstat          = WS_GRANTED;
          s.phase        = PHASE_WRITE;
          s.intn_pending = 1'b0;
        end
      end
      CMD_WRITE_DONE: begin
        if (s.phase == PHASE_WRITE) begin
          s.phase = PHASE_IDLE;
          if (!item.write_ok) begin
            s.err_count = s.err_count + 32'd1;
          end else begin
            ts = try_start(s, item.now_ms, item.now_us);
            s  = ts.st;
            if (ts.go) begin
              rd_start = RD_HEADER;
              rd_len   = HDR_LEN;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign state_next = s;

  assign result.read_start       = rd_start;
  assign result.read_length      = rd_len;
  assign result.chip_select      = (s.phase != PHASE_IDLE);
  assign result.phase_now        = s.phase;
  assign result.packet_delivered = delivered;
  assign result.packet_length    = dlen;
  assign result.packet_stamp     = dstamp;
  assign result.write_status     = wstat;
  assign result.watchdog_fired   = wd;
  assign result.packets_received = s.rx_count;
  assign result.errors_seen      = s.err_count;

endmodule

// ===== hw/rtl/shtp_spi_receive_sequencer.sv =====
// Host-side receive sequencer for a framed SPI sensor-hub transport. One event beat
// (kind in s_tuser) may be accepted every clock cycle while the output is not stalled,
// and each beat yields exactly one result beat on the master side: the event is first
// captured in the input register, and then the single pass through the step
// logic loads the result register, updating the phase and counter state as it does.
// While a result is held, one further event is taken into the input register; after
// that s_tready stays low until the held result is accepted. Configuration writes are
// always accepted and should be issued only while no event is in flight.
module shtp_spi_receive_sequencer #(
  parameter int unsigned HEADER_BYTES = shtp_pkg::HEADER_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // header_low, header_high, write_length, write_ok, now_ms, now_us, zero pad
  input  logic [103:0] s_tdata,
  // cmd
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // read_start, read_length, chip_select, phase_now, packet_delivered, packet_length,
  // packet_stamp, write_status, watchdog_fired, packets_received, errors_seen
  output logic [135:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import shtp_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_result;
  state_t  state;
  state_t  state_next;
  result_t result;
  cfg_t    cfg;
  logic    out_load;

  assign cfg_ready = 1'b1;

  shtp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  shtp_step #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_step (
    .state      (state),
    .item       (in_item),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (result)
  );

  assign out_load = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.cmd          <= s_tuser;
      in_item.header_low   <= s_tdata[7:0];
      in_item.header_high  <= s_tdata[15:8];
      in_item.write_length <= s_tdata[31:16];
      in_item.write_ok     <= s_tdata[32];
      in_item.now_ms       <= s_tdata[64:33];
      in_item.now_us       <= s_tdata[96:65];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_result <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (out_load) begin
      state <= state_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_result.errors_seen, out_result.packets_received,
                     out_result.watchdog_fired, out_result.write_status,
                     out_result.packet_stamp, out_result.packet_length,
                     out_result.packet_delivered, out_result.phase_now,
                     out_result.chip_select, out_result.read_length,
                     out_result.read_start};

endmodule
